>>> hdl/rbs_pkg.sv
// Shared types and constants for the row binomial smoother.
// No dependencies; every other file but rbs_ram refers into it by scoped names.
package rbs_pkg;

    localparam int COMP_WIDTH = 24;
    localparam int CELL_IDX_W = 6;
    localparam int REQ_W      = 2;
    localparam int KW         = 5;   // signed kernel factor: -1 or 0..15
    localparam int PASS_W     = 5;   // up to 15 binomial passes plus compensator
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // request type codes
    localparam logic [REQ_W-1:0] REQ_LEFT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CELL  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RIGHT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_PASSES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPENSATED = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC   = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]             req_type;
        logic signed [COMP_WIDTH-1:0] comp_x;
        logic signed [COMP_WIDTH-1:0] comp_y;
        logic signed [COMP_WIDTH-1:0] comp_z;
    } req_item_t;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] out_x;
        logic signed [COMP_WIDTH-1:0] out_y;
        logic signed [COMP_WIDTH-1:0] out_z;
        logic [CELL_IDX_W-1:0]        cell_index;
        logic                         last_cell;
        logic                         saturated;
    } rsp_item_t;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] x;
        logic signed [COMP_WIDTH-1:0] y;
        logic signed [COMP_WIDTH-1:0] z;
    } cell_t;

    // one row store word: sticky saturation mark plus the cell
    typedef struct packed {
        logic  sat;
        cell_t val;
    } word_t;

    localparam int WORD_W = $bits(word_t);

endpackage

>>> hdl/rbs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/rbs_lane.sv
// One component lane of the smoothing kernel: 3-tap weighted sum,
// round to nearest (ties up) of sum/4, saturate. Uses rbs_pkg.
module rbs_lane (
    input  logic signed [rbs_pkg::COMP_WIDTH-1:0] lo,
    input  logic signed [rbs_pkg::COMP_WIDTH-1:0] cur,
    input  logic signed [rbs_pkg::COMP_WIDTH-1:0] hi,
    input  logic signed [rbs_pkg::KW-1:0]         k,
    output logic signed [rbs_pkg::COMP_WIDTH-1:0] res,
    output logic                                  sat
);

    localparam int W  = rbs_pkg::COMP_WIDTH;
    localparam int DW = W + 2;
    localparam int PW = DW + rbs_pkg::KW;
    localparam int SW = PW + 1;
    localparam int QW = SW - 2;

    // 4*sum = 4*cur + k*(2*cur - lo - hi); k = -1 gives [1,2,1], k = n the compensator
    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod;
    logic signed [SW-1:0] sum4;
    logic signed [SW-1:0] biased;
    logic signed [QW-1:0] quot;

    always_comb
    begin
        diff   = (DW'(cur) <<< 1) - DW'(lo) - DW'(hi);
        prod   = PW'(k) * PW'(diff);
        sum4   = (SW'(cur) <<< 2) + SW'(prod);
        biased = sum4 + SW'(2);
        quot   = QW'(biased >>> 2);
        sat    = !((&quot[QW-1:W-1]) || !(|quot[QW-1:W-1]));
        if (sat)
        begin
            res = quot[QW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        else
        begin
            res = quot[W-1:0];
        end
    end

endmodule

>>> hdl/row_binomial_smoother.sv
// Row binomial smoother: loads a guarded row of 3-component cells, runs the
// configured [1/4,1/2,1/4] passes (plus optional compensator) and emits the row.
// Loading takes one item per cycle. On the right guard, P = x_passes (+1 with
// compensator when x_passes != 0) sweeps over the row, a setup state, then a load
// and a hold state per result: input stalls through all of it, plus result stalls.
// Reset is asynchronous: config to reset values, guards zero, no RAM clearing.
module row_binomial_smoother #(
    parameter int MAX_ROW = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              req_valid,
    output logic                              req_stall,
    input  rbs_pkg::req_item_t                req_item,
    // result channel
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output rbs_pkg::rsp_item_t                rsp_item,
    // configuration
    input  logic                              cfg_write,
    input  logic [rbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rbs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CNT_W = $clog2(MAX_ROW + 1);     // holds 0..MAX_ROW
    localparam int AW    = MAX_ROW > 1 ? $clog2(MAX_ROW) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_P_START,   // read first cell of the pass
        S_P_FILL,    // prime the window, read second cell
        S_P_RUN,     // one cell per cycle through the lanes
        S_E_RD,      // first read of emission
        S_E_LD,      // load output register
        S_E_HOLD     // wait for result to be taken
    } state_t;

    // control state
    state_t                       state_reg, state_next;
    logic [CNT_W-1:0]             load_cnt_reg, load_cnt_next;
    logic [CNT_W-1:0]             n_reg, n_next;
    logic [CNT_W-1:0]             idx_reg, idx_next;
    logic [rbs_pkg::PASS_W-1:0]   pass_reg, pass_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    rbs_pkg::cell_t               lg_reg, lg_next;    // left guard
    rbs_pkg::cell_t               rg_reg, rg_next;    // right guard

    // configuration registers
    logic [6:0]                   row_length_reg, row_length_next;
    logic [3:0]                   x_passes_reg, x_passes_next;
    logic                         comp_reg, comp_next;
    logic                         periodic_reg, periodic_next;

    // datapath registers (no reset)
    rbs_pkg::cell_t               prev_reg, prev_next;
    rbs_pkg::cell_t               cur_reg, cur_next;
    logic                         cur_sat_reg, cur_sat_next;
    rbs_pkg::cell_t               new_rg_reg, new_rg_next;
    rbs_pkg::rsp_item_t           rsp_item_reg, rsp_item_next;

    // RAM ports
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    rbs_pkg::word_t               ram_wdata;
    logic [AW-1:0]                ram_raddr;
    rbs_pkg::word_t               ram_rdata;

    // lanes
    rbs_pkg::cell_t               hi_cell;
    rbs_pkg::cell_t               res_cell;
    logic [2:0]                   lane_sat;
    logic signed [rbs_pkg::KW-1:0] k_val;

    // misc
    logic                         req_acc;
    logic                         rsp_acc;
    logic [CNT_W-1:0]             cap;
    logic [CNT_W-1:0]             last_idx;
    logic                         at_last;
    logic [rbs_pkg::PASS_W-1:0]   total_passes;
    rbs_pkg::cell_t               in_cell;

    assign req_acc  = req_valid && !req_stall;
    assign rsp_acc  = rsp_valid_reg && !rsp_stall;
    assign in_cell  = '{x: req_item.comp_x, y: req_item.comp_y, z: req_item.comp_z};
    assign last_idx = CNT_W'(n_reg - 1'b1);
    assign at_last  = (idx_reg == last_idx);

    // row_length above MAX_ROW acts as MAX_ROW
    assign cap = (int'(row_length_reg) > MAX_ROW) ? CNT_W'(MAX_ROW) : CNT_W'(row_length_reg);

    // compensator only counts when there is at least one binomial pass
    assign total_passes = rbs_pkg::PASS_W'(x_passes_reg)
                        + rbs_pkg::PASS_W'(comp_reg && (x_passes_reg != 4'd0));

    // binomial passes use k = -1; the trailing compensator pass uses k = x_passes
    assign k_val = (pass_reg == rbs_pkg::PASS_W'(x_passes_reg))
                 ? rbs_pkg::KW'(signed'({1'b0, x_passes_reg}))
                 : -rbs_pkg::KW'(1);

    // upper neighbor: stored cell, or the right guard at the row end
    assign hi_cell = at_last ? rg_reg : ram_rdata.val;

    rbs_ram #(
        .WIDTH (rbs_pkg::WORD_W),
        .DEPTH (MAX_ROW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // three component lanes side by side
    rbs_lane u_lane_x (
        .lo  (prev_reg.x),
        .cur (cur_reg.x),
        .hi  (hi_cell.x),
        .k   (k_val),
        .res (res_cell.x),
        .sat (lane_sat[0])
    );

    rbs_lane u_lane_y (
        .lo  (prev_reg.y),
        .cur (cur_reg.y),
        .hi  (hi_cell.y),
        .k   (k_val),
        .res (res_cell.y),
        .sat (lane_sat[1])
    );

    rbs_lane u_lane_z (
        .lo  (prev_reg.z),
        .cur (cur_reg.z),
        .hi  (hi_cell.z),
        .k   (k_val),
        .res (res_cell.z),
        .sat (lane_sat[2])
    );

    always_comb
    begin
        state_next      = state_reg;
        load_cnt_next   = load_cnt_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        pass_next       = pass_reg;
        rsp_valid_next  = rsp_valid_reg;
        lg_next         = lg_reg;
        rg_next         = rg_reg;
        row_length_next = row_length_reg;
        x_passes_next   = x_passes_reg;
        comp_next       = comp_reg;
        periodic_next   = periodic_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        cur_sat_next    = cur_sat_reg;
        new_rg_next     = new_rg_reg;
        rsp_item_next   = rsp_item_reg;

        ram_we    = 1'b0;
        ram_waddr = AW'(load_cnt_reg);
        ram_wdata = '{sat: 1'b0, val: in_cell};
        ram_raddr = AW'(idx_reg);

        if (cfg_write)
        begin
            unique case (cfg_index)
                rbs_pkg::CFG_ROW_LENGTH:  row_length_next = cfg_data;
                rbs_pkg::CFG_X_PASSES:    x_passes_next   = cfg_data[3:0];
                rbs_pkg::CFG_COMPENSATED: comp_next       = cfg_data[0];
                rbs_pkg::CFG_PERIODIC:    periodic_next   = cfg_data[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    case (req_item.req_type)
                        rbs_pkg::REQ_LEFT:
                        begin
                            lg_next = in_cell;
                        end
                        rbs_pkg::REQ_CELL:
                        begin
                            // surplus cells beyond the cap are dropped
                            if (load_cnt_reg < cap)
                            begin
                                ram_we        = 1'b1;
                                load_cnt_next = load_cnt_reg + 1'b1;
                            end
                        end
                        rbs_pkg::REQ_RIGHT:
                        begin
                            rg_next       = in_cell;
                            n_next        = load_cnt_reg;
                            load_cnt_next = '0;
                            idx_next      = '0;
                            pass_next     = '0;
                            if (load_cnt_reg != '0)
                            begin
                                state_next = (total_passes == '0) ? S_E_RD : S_P_START;
                            end
                        end
                        default: ;   // unknown type is ignored
                    endcase
                end
            end

            S_P_START:
            begin
                ram_raddr  = '0;
                state_next = S_P_FILL;
            end

            S_P_FILL:
            begin
                prev_next    = lg_reg;
                cur_next     = ram_rdata.val;
                cur_sat_next = ram_rdata.sat;
                idx_next     = '0;
                ram_raddr    = AW'(1);
                state_next   = S_P_RUN;
            end

            S_P_RUN:
            begin
                // write back cell idx; reads run two ahead so old values stay intact
                ram_we    = 1'b1;
                ram_waddr = AW'(idx_reg);
                ram_wdata = '{sat: cur_sat_reg || (|lane_sat), val: res_cell};
                ram_raddr = AW'(idx_reg + 2'd2);

                prev_next    = cur_reg;
                cur_next     = ram_rdata.val;
                cur_sat_next = ram_rdata.sat;
                if (idx_reg == '0)
                begin
                    new_rg_next = res_cell;
                end

                if (at_last)
                begin
                    // guards rewrap only after the whole pass is done
                    if (periodic_reg)
                    begin
                        lg_next = res_cell;
                        rg_next = (idx_reg == '0) ? res_cell : new_rg_reg;
                    end
                    idx_next = '0;
                    if (pass_reg == total_passes - 1'b1)
                    begin
                        state_next = S_E_RD;
                    end
                    else
                    begin
                        pass_next  = pass_reg + 1'b1;
                        state_next = S_P_START;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_E_RD:
            begin
                ram_raddr  = AW'(idx_reg);
                state_next = S_E_LD;
            end

            S_E_LD:
            begin
                rsp_item_next.out_x      = ram_rdata.val.x;
                rsp_item_next.out_y      = ram_rdata.val.y;
                rsp_item_next.out_z      = ram_rdata.val.z;
                rsp_item_next.cell_index = rbs_pkg::CELL_IDX_W'(idx_reg);
                rsp_item_next.last_cell  = at_last;
                rsp_item_next.saturated  = ram_rdata.sat;
                rsp_valid_next           = 1'b1;
                ram_raddr                = AW'(idx_reg + 1'b1);   // prefetch next
                state_next               = S_E_HOLD;
            end

            S_E_HOLD:
            begin
                ram_raddr = AW'(idx_reg + 1'b1);
                if (rsp_acc)
                begin
                    rsp_valid_next = 1'b0;
                    if (at_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_E_LD;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            load_cnt_reg   <= '0;
            n_reg          <= '0;
            idx_reg        <= '0;
            pass_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
            lg_reg         <= '0;
            rg_reg         <= '0;
            row_length_reg <= 7'd64;
            x_passes_reg   <= 4'd0;
            comp_reg       <= 1'b0;
            periodic_reg   <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            load_cnt_reg   <= load_cnt_next;
            n_reg          <= n_next;
            idx_reg        <= idx_next;
            pass_reg       <= pass_next;
            rsp_valid_reg  <= rsp_valid_next;
            lg_reg         <= lg_next;
            rg_reg         <= rg_next;
            row_length_reg <= row_length_next;
            x_passes_reg   <= x_passes_next;
            comp_reg       <= comp_next;
            periodic_reg   <= periodic_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        cur_sat_reg  <= cur_sat_next;
        new_rg_reg   <= new_rg_next;
        rsp_item_reg <= rsp_item_next;
    end

    // one row at a time: requests wait while a row is processed or emitted
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

>>> hdl/rbs_checker.sv
// Port-level checks for the row binomial smoother, bound to the top level.
// Uses rbs_pkg types; attached by the bind statement at the end.
module rbs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input rbs_pkg::rsp_item_t rsp_item
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
    else $error("stalled result changed");

    // no new request is taken while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> req_stall)
    else $error("request accepted while result pending");

    // after a non-final cell the next one follows with the next index
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_stall && !rsp_item.last_cell
        |=> !rsp_valid ##1 (rsp_valid && rsp_item.cell_index ==
            rbs_pkg::CELL_IDX_W'($past(rsp_item.cell_index, 2) + 1'b1)))
    else $error("result index sequence broken");

    // the final cell closes the row
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_stall && rsp_item.last_cell |=> !rsp_valid)
    else $error("result after final cell");

endmodule

bind row_binomial_smoother rbs_checker u_rbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
);

>>> bench/row_binomial_smoother_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for row_binomial_smoother: directed rows, random rows,
// back pressure and flush phases. Depends only on rbs_pkg and the block itself.
module row_binomial_smoother_tb;

    localparam int MAX_ROW      = 64;
    localparam int CYCLE_LIMIT  = 600000;
    // worst busy time after the last item: (16 sweeps + emit) on a 64-cell row
    localparam int DRAIN_CYCLES = 1400;
    localparam int RANDOM_GOAL  = 320;

    // request code the block has to ignore
    localparam logic [rbs_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic [rbs_pkg::COMP_WIDTH-1:0] COMP_MAX  = 24'h7FFFFF;
    localparam logic [rbs_pkg::COMP_WIDTH-1:0] COMP_MIN  = 24'h800000;
    localparam logic [rbs_pkg::COMP_WIDTH-1:0] COMP_NEG1 = 24'hFFFFFF;
    localparam logic [rbs_pkg::COMP_WIDTH-1:0] COMP_ZERO = 24'h000000;

    localparam longint SAT_HI = (64'sd1 <<< (rbs_pkg::COMP_WIDTH - 1)) - 1;
    localparam longint SAT_LO = -(64'sd1 <<< (rbs_pkg::COMP_WIDTH - 1));

    logic                           clk;
    logic                           rst_n;
    logic                           req_valid;
    logic                           req_stall;
    rbs_pkg::req_item_t             req_item;
    logic                           rsp_valid;
    logic                           rsp_stall;
    rbs_pkg::rsp_item_t             rsp_item;
    logic                           cfg_write;
    logic [rbs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rbs_pkg::CFG_DATA_W-1:0] cfg_data;

    row_binomial_smoother dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Row smoother prediction: own copy of registers, row and guards.
    // ------------------------------------------------------------------
    logic [6:0] row_len_reg;
    logic [3:0] passes_reg;
    bit         comp_reg;
    bit         wrap_reg;

    longint     row_vals [MAX_ROW][3];
    longint     left_edge [3];
    longint     right_edge [3];
    int         cells_loaded;
    bit         sat_flags [MAX_ROW];

    rbs_pkg::rsp_item_t smoothed_cells [$];   // cells still owed by the block

    int         errors;
    int         items_sent;
    int         cells_checked;
    int         sat_seen;
    int         settings_used;
    int         cycle_count;

    // receiver controls
    bit         calm;            // no idling on either side while set
    int         hold_request;    // long hold-off asked of the receiver
    int         hold_left;

    function automatic void clear_prediction();
        row_len_reg  = 7'd64;
        passes_reg   = 4'd0;
        comp_reg     = 1'b0;
        wrap_reg     = 1'b1;
        cells_loaded = 0;
        for (int c = 0; c < 3; c++)
        begin
            left_edge[c]  = 0;
            right_edge[c] = 0;
        end
        for (int i = 0; i < MAX_ROW; i++)
            sat_flags[i] = 1'b0;
    endfunction

    // One sweep with weights wa/4 on neighbors and wb/4 on the center.
    // Quotient rounds half up (floor of (s+2)/4), then clamps.
    function automatic void smooth_sweep(int n, longint wa, longint wb);
        longint nxt [MAX_ROW][3];
        longint lo;
        longint hi;
        longint q;
        for (int i = 0; i < n; i++)
            for (int c = 0; c < 3; c++)
            begin
                lo = (i == 0) ? left_edge[c] : row_vals[i-1][c];
                hi = (i == n - 1) ? right_edge[c] : row_vals[i+1][c];
                q  = (wa * lo + wb * row_vals[i][c] + wa * hi + 2) >>> 2;
                if (q > SAT_HI)
                begin
                    q = SAT_HI;
                    sat_flags[i] = 1'b1;
                end
                else if (q < SAT_LO)
                begin
                    q = SAT_LO;
                    sat_flags[i] = 1'b1;
                end
                nxt[i][c] = q;
            end
        for (int i = 0; i < n; i++)
            for (int c = 0; c < 3; c++)
                row_vals[i][c] = nxt[i][c];
        if (wrap_reg)
            for (int c = 0; c < 3; c++)
            begin
                left_edge[c]  = row_vals[n-1][c];
                right_edge[c] = row_vals[0][c];
            end
    endfunction

    function automatic void predict_item(rbs_pkg::req_item_t it);
        longint             v [3];
        int                 cap;
        int                 n;
        rbs_pkg::rsp_item_t r;
        v[0] = $signed(it.comp_x);
        v[1] = $signed(it.comp_y);
        v[2] = $signed(it.comp_z);
        cap  = (row_len_reg > MAX_ROW) ? MAX_ROW : row_len_reg;
        case (it.req_type)
            rbs_pkg::REQ_LEFT:
                for (int c = 0; c < 3; c++)
                    left_edge[c] = v[c];
            rbs_pkg::REQ_CELL:
                if (cells_loaded < cap)
                begin
                    for (int c = 0; c < 3; c++)
                        row_vals[cells_loaded][c] = v[c];
                    sat_flags[cells_loaded] = 1'b0;
                    cells_loaded++;
                end
            rbs_pkg::REQ_RIGHT:
            begin
                for (int c = 0; c < 3; c++)
                    right_edge[c] = v[c];
                n = cells_loaded;
                cells_loaded = 0;
                if (n > 0)
                begin
                    for (int i = 0; i < n; i++)
                        sat_flags[i] = 1'b0;
                    for (int p = 0; p < passes_reg; p++)
                        smooth_sweep(n, 1, 2);
                    // compensator is skipped when there are no passes
                    if (comp_reg && passes_reg != 0)
                        smooth_sweep(n, -longint'(passes_reg), 4 + 2 * longint'(passes_reg));
                    for (int i = 0; i < n; i++)
                    begin
                        r.out_x      = row_vals[i][0][rbs_pkg::COMP_WIDTH-1:0];
                        r.out_y      = row_vals[i][1][rbs_pkg::COMP_WIDTH-1:0];
                        r.out_z      = row_vals[i][2][rbs_pkg::COMP_WIDTH-1:0];
                        r.cell_index = i[rbs_pkg::CELL_IDX_W-1:0];
                        r.last_cell  = (i == n - 1);
                        r.saturated  = sat_flags[i];
                        smoothed_cells.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d cells still owed", $time, smoothed_cells.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall, calm stretches, and a long counted hold-off.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_request > 0)
        begin
            rsp_stall    <= 1'b1;
            hold_left    = hold_request - 1;
            hold_request = 0;
        end
        else if (calm)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < 24);
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted cell against the oldest prediction.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        rbs_pkg::rsp_item_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (smoothed_cells.size() == 0)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected cell, expected none, actual index %0d",
                             $time, rsp_item.cell_index);
            end
            else
            begin
                want = smoothed_cells.pop_front();
                check_field("out_x", want.out_x, rsp_item.out_x);
                check_field("out_y", want.out_y, rsp_item.out_y);
                check_field("out_z", want.out_z, rsp_item.out_z);
                check_field("cell_index", want.cell_index, rsp_item.cell_index);
                check_field("last_cell", want.last_cell, rsp_item.last_cell);
                check_field("saturated", want.saturated, rsp_item.saturated);
                cells_checked++;
                if (want.saturated)
                    sat_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic rbs_pkg::req_item_t pack_req(logic [rbs_pkg::REQ_W-1:0] kind,
                                                    logic [rbs_pkg::COMP_WIDTH-1:0] x,
                                                    logic [rbs_pkg::COMP_WIDTH-1:0] y,
                                                    logic [rbs_pkg::COMP_WIDTH-1:0] z);
        rbs_pkg::req_item_t it;
        it.req_type = kind;
        it.comp_x   = x;
        it.comp_y   = y;
        it.comp_z   = z;
        return it;
    endfunction

    // full range, extremes, or small values that keep rows smooth
    function automatic logic [rbs_pkg::COMP_WIDTH-1:0] rand_comp();
        int          pick;
        logic [31:0] raw;
        pick = $urandom_range(99);
        raw  = $urandom;
        if (pick < 30)
            return raw[rbs_pkg::COMP_WIDTH-1:0];
        if (pick < 45)
            case (raw[1:0])
                2'd0:    return COMP_MAX;
                2'd1:    return COMP_MIN;
                2'd2:    return COMP_ZERO;
                default: return COMP_NEG1;
            endcase
        return rbs_pkg::COMP_WIDTH'($urandom_range(8191)) - rbs_pkg::COMP_WIDTH'(4096);
    endfunction

    function automatic rbs_pkg::req_item_t make_item(logic [rbs_pkg::REQ_W-1:0] kind);
        return pack_req(kind, rand_comp(), rand_comp(), rand_comp());
    endfunction

    // Offer one item, hold it until accepted, then predict it.
    // Valid stays high on return; a caller that stops sending must drop it.
    task automatic send_item(rbs_pkg::req_item_t it);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 24)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        predict_item(it);
        if (it.req_type != REQ_UNUSED)
            items_sent++;
    endtask

    // Stop offering and wait for every owed cell.
    task automatic wait_results_done();
        @(negedge clk);
        req_valid <= 1'b0;
        while (smoothed_cells.size() != 0)
            @(posedge clk);
    endtask

    // Owed cells in, plus room for a sweep with nothing to show for it.
    task automatic wait_idle();
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [rbs_pkg::CFG_IDX_W-1:0] idx,
                             logic [rbs_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    task automatic configure(logic [6:0] len, logic [3:0] passes, bit comp, bit wrap);
        wait_idle();
        write_reg(rbs_pkg::CFG_ROW_LENGTH, len);
        write_reg(rbs_pkg::CFG_X_PASSES, rbs_pkg::CFG_DATA_W'(passes));
        write_reg(rbs_pkg::CFG_COMPENSATED, rbs_pkg::CFG_DATA_W'(comp));
        write_reg(rbs_pkg::CFG_PERIODIC, rbs_pkg::CFG_DATA_W'(wrap));
        @(negedge clk);
        cfg_write   <= 1'b0;
        row_len_reg = len;
        passes_reg  = passes;
        comp_reg    = comp;
        wrap_reg    = wrap;
        settings_used++;
    endtask

    task automatic send_row(int n);
        send_item(make_item(rbs_pkg::REQ_LEFT));
        repeat (n) send_item(make_item(rbs_pkg::REQ_CELL));
        send_item(make_item(rbs_pkg::REQ_RIGHT));
    endtask

    // Mostly well-formed rows of random length; some noise and broken rows.
    task automatic send_random_row();
        int cap;
        int lim;
        int k;
        int pick;
        cap  = (row_len_reg > MAX_ROW) ? MAX_ROW : row_len_reg;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            case ($urandom_range(2))
                0:       send_item(make_item(REQ_UNUSED));
                1:       send_item(make_item(rbs_pkg::REQ_CELL));
                default: send_item(make_item(rbs_pkg::REQ_RIGHT));
            endcase
            return;
        end
        if (pick < 95)
            send_item(make_item(rbs_pkg::REQ_LEFT));
        if ($urandom_range(19) == 0)
            send_item(make_item(rbs_pkg::REQ_LEFT));
        pick = $urandom_range(99);
        lim  = (cap < 12) ? cap : 12;
        if (pick < 6)
            k = 0;
        else if (pick < 76)
            k = $urandom_range(6, 1);
        else if (pick < 98)
            k = $urandom_range(lim + 2, 1);
        else
            k = cap + $urandom_range(2);    // full row, maybe with surplus
        repeat (k)
        begin
            if ($urandom_range(99) < 3)
                send_item(make_item(REQ_UNUSED));
            send_item(make_item(rbs_pkg::REQ_CELL));
        end
        send_item(make_item(rbs_pkg::REQ_RIGHT));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings (64 cells, no passes, periodic): extremes pass through.
    task automatic test_reset_config();
        send_item(pack_req(rbs_pkg::REQ_LEFT, COMP_MAX, COMP_MIN, COMP_ZERO));
        send_item(pack_req(rbs_pkg::REQ_CELL, COMP_MAX, COMP_MIN, COMP_NEG1));
        send_item(pack_req(rbs_pkg::REQ_CELL, COMP_MIN, COMP_MAX, COMP_ZERO));
        send_item(pack_req(rbs_pkg::REQ_CELL, COMP_ZERO, COMP_NEG1, COMP_MAX));
        send_item(pack_req(REQ_UNUSED, COMP_MAX, COMP_MAX, COMP_MAX));
        send_item(pack_req(rbs_pkg::REQ_CELL, COMP_NEG1, COMP_ZERO, COMP_MIN));
        send_item(pack_req(rbs_pkg::REQ_RIGHT, COMP_MIN, COMP_MAX, COMP_NEG1));
    endtask

    // Steep edges under 15 passes plus compensator drive saturation;
    // then compensator with zero passes must leave cells untouched.
    task automatic test_compensator();
        configure(7'd64, 4'd15, 1'b1, 1'b0);
        send_item(pack_req(rbs_pkg::REQ_LEFT, COMP_MIN, COMP_MAX, COMP_MIN));
        send_item(pack_req(rbs_pkg::REQ_CELL, COMP_MAX, COMP_MIN, COMP_MAX));
        send_item(pack_req(rbs_pkg::REQ_CELL, COMP_MAX, COMP_MIN, COMP_MIN));
        send_item(pack_req(rbs_pkg::REQ_CELL, COMP_MAX, COMP_MIN, COMP_MAX));
        send_item(pack_req(rbs_pkg::REQ_RIGHT, COMP_MIN, COMP_MAX, COMP_MIN));
        configure(7'd2, 4'd0, 1'b1, 1'b1);
        send_row(3);    // third cell is surplus
    endtask

    // Empty row, repeated left guard on a short row, row length zero.
    task automatic test_short_rows();
        configure(7'd4, 4'd1, 1'b0, 1'b0);
        send_item(make_item(rbs_pkg::REQ_RIGHT));
        send_item(pack_req(rbs_pkg::REQ_LEFT, COMP_MIN, COMP_MIN, COMP_MIN));
        send_item(pack_req(rbs_pkg::REQ_LEFT, COMP_MAX, COMP_ZERO, COMP_NEG1));
        send_item(make_item(rbs_pkg::REQ_CELL));
        send_item(make_item(rbs_pkg::REQ_RIGHT));
        configure(7'd0, 4'd2, 1'b0, 1'b1);
        send_item(make_item(rbs_pkg::REQ_CELL));
        send_item(make_item(rbs_pkg::REQ_RIGHT));
    endtask

    // Random rows across many settings; the first few phases pin extremes.
    task automatic test_random_rows();
        int phase;
        int start;
        int len;
        int pick;
        phase = 0;
        while (items_sent < RANDOM_GOAL)
        begin
            case (phase)
                0: configure(7'd127, 4'd15, 1'b1, 1'b1);
                1: configure(7'd1, 4'd15, 1'b1, 1'b0);
                2: configure(7'd64, 4'd0, 1'b1, 1'b0);
                3: configure(7'd127, 4'd0, 1'b0, 1'b1);
                default:
                begin
                    pick = $urandom_range(99);
                    if (pick < 50)
                        len = $urandom_range(8, 1);
                    else if (pick < 65)
                        len = $urandom_range(63, 9);
                    else if (pick < 80)
                        len = MAX_ROW;
                    else if (pick < 95)
                        len = $urandom_range(127, 65);
                    else
                        len = 0;
                    configure(7'(len), 4'($urandom_range(15)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                end
            endcase
            phase++;
            start = items_sent;
            while (items_sent - start < 25 && items_sent < RANDOM_GOAL)
                send_random_row();
        end
    endtask

    // Receiver holds off for a long counted stretch while rows keep coming,
    // so the block fills and has to stall its input.
    task automatic test_back_pressure();
        configure(7'd8, 4'd2, 1'b0, 1'b1);
        hold_request = 300;
        repeat (5) send_row(8);
    endtask

    // No idling on either side; sender waits for each row to drain.
    task automatic test_pause_and_flush();
        configure(7'd6, 4'd4, 1'b1, 1'b1);
        calm = 1'b1;
        repeat (3)
        begin
            send_row($urandom_range(6, 1));
            wait_results_done();
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req_item      = '0;
        rsp_stall     = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        errors        = 0;
        items_sent    = 0;
        cells_checked = 0;
        sat_seen      = 0;
        settings_used = 0;
        cycle_count   = 0;
        calm          = 1'b0;
        hold_request  = 0;
        hold_left     = 0;
        clear_prediction();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_config();
        test_compensator();
        test_short_rows();
        test_random_rows();
        test_back_pressure();
        test_pause_and_flush();

        wait_idle();
        $display("run covered %0d items under %0d register settings;",
                 items_sent, settings_used);
        $display("%0d cells checked, %0d of them saturated", cells_checked, sat_seen);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
